>>> design/ltps_pkg.sv
// Package for the line tracker PID steering block: types, constants, tables.
`default_nettype none

package ltps_pkg;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    CFG_KP      = 3'd0,
    CFG_KI      = 3'd1,
    CFG_KD      = 3'd2,
    CFG_INT_MAX = 3'd3,
    CFG_INT_MIN = 3'd4,
    CFG_OUT_MAX = 3'd5,
    CFG_OUT_MIN = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] kp;
    logic signed [15:0] ki;
    logic signed [15:0] kd;
    logic signed [23:0] integral_max;
    logic signed [23:0] integral_min;
    logic signed [31:0] output_max;
    logic signed [31:0] output_min;
  } pid_cfg_t;

  // Classified scan word passed from front to back
  typedef struct packed {
    logic               lost;
    logic signed [8:0]  wsum;
    logic [3:0]         count;
    logic signed [15:0] speed;
  } scan_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_POS,
    ST_ERR,
    ST_SGN,
    ST_INT,
    ST_MI,
    ST_MD,
    ST_SUM,
    ST_OMG,
    ST_OUT
  } back_state_e;

  localparam logic signed [8:0] ProbeWeight [8] = '{
    -9'sd35, -9'sd25, -9'sd15, -9'sd5, 9'sd5, 9'sd15, 9'sd25, 9'sd35
  };

  // ceil(2^CountShift / count), exact for 16-bit dividends
  localparam int unsigned CountShift = 20;
  // ceil(2^ErrShift / 35), exact for 21-bit dividends
  localparam int unsigned ErrShift = 28;
  localparam logic [22:0] ErrRecip = 23'd7669585;

  localparam logic signed [15:0] ErrPosMax = 16'sh7FFF;

  function automatic logic [20:0] count_recip(input logic [3:0] cnt);
    logic [20:0] r;
    unique case (cnt)
      4'd1:    r = 21'd1048576;
      4'd2:    r = 21'd524288;
      4'd3:    r = 21'd349526;
      4'd4:    r = 21'd262144;
      4'd5:    r = 21'd209716;
      4'd6:    r = 21'd174763;
      4'd7:    r = 21'd149797;
      4'd8:    r = 21'd131072;
      default: r = 21'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/ltps_front.sv
// Front end: weighted sum and probe count of one sensor scan.
`default_nettype none

module ltps_front (
  input  wire logic [7:0]         sensor_bits_i,
  input  wire logic signed [15:0] forward_speed_i,
  output ltps_pkg::scan_item_t    item_o
);
  import ltps_pkg::*;

  logic signed [8:0] wsum;
  logic [3:0]        cnt;

  always_comb begin
    wsum = '0;
    cnt  = '0;
    for (int i = 0; i < 8; i++) begin
      if (sensor_bits_i[i]) begin
        wsum = wsum + ProbeWeight[i];
        cnt  = cnt + 4'd1;
      end
    end
  end

  assign item_o.lost  = (sensor_bits_i == 8'h00);
  assign item_o.wsum  = wsum;
  assign item_o.count = cnt;
  assign item_o.speed = forward_speed_i;

endmodule

`default_nettype wire

>>> design/ltps_fifo.sv
// Short queue of classified scans between front and back.
`default_nettype none

module ltps_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_valid_i,
  output logic                      push_ready_o,
  input  ltps_pkg::scan_item_t      push_item_i,
  output logic                      pop_valid_o,
  input  wire logic                 pop_i,
  output ltps_pkg::scan_item_t      pop_item_o
);
  import ltps_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  scan_item_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue fill above depth");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");
`endif

endmodule

`default_nettype wire

>>> design/ltps_back.sv
// Back end: position divide, error scaling, PID sequencer and result register.
`default_nettype none

module ltps_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  ltps_pkg::pid_cfg_t        cfg_i,
  input  wire logic                 q_valid_i,
  input  ltps_pkg::scan_item_t      q_item_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic signed [15:0]        speed_out_o,
  output logic signed [31:0]        omega_o,
  output logic signed [14:0]        line_position_o,
  output logic signed [15:0]        line_error_o,
  output logic                      line_lost_o
);
  import ltps_pkg::*;

  back_state_e state_q, state_d;
  logic        out_load;

  scan_item_t         item_q;
  logic [13:0]        qmag_q;
  logic [15:0]        emag_q;
  logic signed [40:0] prod_q, prod_d;
  logic signed [40:0] acc_q, acc_d;

  logic signed [14:0] held_pos_q, held_pos_d;
  logic signed [15:0] err_q, err_d;
  logic signed [15:0] prev_err_q, prev_err_d;
  logic signed [23:0] integ_q, integ_d;
  logic signed [31:0] held_omega_q, held_omega_d;

  logic               out_valid_q, out_valid_d;
  logic signed [15:0] out_speed_q;
  logic signed [31:0] out_omega_q;
  logic signed [14:0] out_pos_q;
  logic signed [15:0] out_err_q;
  logic               out_lost_q;

  // datapath terms
  logic [8:0]         wabs;
  logic [15:0]        dmag;
  logic [36:0]        dprod;
  logic [14:0]        hp_abs;
  logic [20:0]        emag_in;
  logic [43:0]        eprod;
  logic signed [16:0] e17;
  logic signed [24:0] isum;
  logic signed [31:0] p_kp;
  logic signed [39:0] p_ki;
  logic signed [16:0] ediff;
  logic signed [32:0] p_kd;
  logic signed [33:0] acc_sh;

  assign wabs    = item_q.wsum[8] ? 9'(-item_q.wsum) : 9'(item_q.wsum);
  assign dmag    = {wabs[7:0], 8'h00};
  assign dprod   = 37'(dmag) * 37'(count_recip(item_q.count));
  assign hp_abs  = held_pos_q[14] ? 15'(-held_pos_q) : 15'(held_pos_q);
  assign emag_in = {hp_abs[13:0], 7'b0};
  assign eprod   = 44'(emag_in) * 44'(ErrRecip);
  assign e17     = held_pos_q[14] ? -$signed({1'b0, emag_q}) : $signed({1'b0, emag_q});
  assign isum    = 25'(integ_q) + 25'(err_q);
  assign p_kp    = cfg_i.kp * err_q;
  assign p_ki    = cfg_i.ki * integ_q;
  assign ediff   = 17'(err_q) - 17'(prev_err_q);
  assign p_kd    = cfg_i.kd * ediff;
  assign acc_sh  = acc_q[40:7];

  // control decode
  always_comb begin
    q_pop_o  = (state_q == ST_IDLE) && q_valid_i;
    out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (q_valid_i) state_d = ST_DIV;
      ST_DIV:  state_d = ST_POS;
      ST_POS:  state_d = ST_ERR;
      ST_ERR:  state_d = ST_SGN;
      ST_SGN:  state_d = ST_INT;
      ST_INT:  state_d = item_q.lost ? ST_OUT : ST_MI;
      ST_MI:   state_d = ST_MD;
      ST_MD:   state_d = ST_SUM;
      ST_SUM:  state_d = ST_OMG;
      ST_OMG:  state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // state registers of the loop
  always_comb begin
    held_pos_d   = held_pos_q;
    err_d        = err_q;
    prev_err_d   = prev_err_q;
    integ_d      = integ_q;
    held_omega_d = held_omega_q;
    prod_d       = prod_q;
    acc_d        = acc_q;
    unique case (state_q)
      ST_POS: begin
        if (!item_q.lost) begin
          held_pos_d = item_q.wsum[8] ? -$signed({1'b0, qmag_q}) : $signed({1'b0, qmag_q});
        end
      end
      ST_SGN: begin
        err_d = (e17 > 17'(ErrPosMax)) ? ErrPosMax : 16'(e17);
      end
      ST_INT: begin
        if (item_q.lost) begin
          integ_d = '0;
        end else if (isum > 25'(cfg_i.integral_max)) begin
          integ_d = cfg_i.integral_max;
        end else if (isum < 25'(cfg_i.integral_min)) begin
          integ_d = cfg_i.integral_min;
        end else begin
          integ_d = 24'(isum);
        end
        prod_d = 41'(p_kp);
      end
      ST_MI: begin
        acc_d  = prod_q;
        prod_d = 41'(p_ki);
      end
      ST_MD: begin
        acc_d  = acc_q + prod_q;
        prod_d = 41'(p_kd);
      end
      ST_SUM: begin
        acc_d = acc_q + prod_q;
      end
      ST_OMG: begin
        if (acc_sh > 34'(cfg_i.output_max)) begin
          held_omega_d = cfg_i.output_max;
        end else if (acc_sh < 34'(cfg_i.output_min)) begin
          held_omega_d = cfg_i.output_min;
        end else begin
          held_omega_d = 32'(acc_sh);
        end
        prev_err_d = err_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      held_pos_q   <= '0;
      prev_err_q   <= '0;
      integ_q      <= '0;
      held_omega_q <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      held_pos_q   <= held_pos_d;
      prev_err_q   <= prev_err_d;
      integ_q      <= integ_d;
      held_omega_q <= held_omega_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q  <= err_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (q_pop_o) begin
      item_q <= q_item_i;
    end
    if (state_q == ST_DIV) begin
      qmag_q <= dprod[CountShift +: 14];
    end
    if (state_q == ST_ERR) begin
      emag_q <= eprod[ErrShift +: 16];
    end
    if (out_load) begin
      out_speed_q <= item_q.speed;
      out_omega_q <= held_omega_q;
      out_pos_q   <= held_pos_q;
      out_err_q   <= err_q;
      out_lost_q  <= item_q.lost;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign speed_out_o     = out_speed_q;
  assign omega_o         = out_omega_q;
  assign line_position_o = out_pos_q;
  assign line_error_o    = out_err_q;
  assign line_lost_o     = out_lost_q;

`ifndef ASSERT_OFF
  a_lost_skips_pid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INT && item_q.lost) |=> (state_q == ST_OUT && integ_q == '0))
    else $error("lost scan entered PID or kept integral");
  a_prev_err_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OMG) |=> (prev_err_q == $past(err_q)))
    else $error("previous error not updated");
  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (!q_pop_o && ($past(q_pop_o) || $stable(item_q))))
    else $error("scan taken while busy");
`endif

endmodule

`default_nettype wire

>>> design/line_track_pid_steer.sv
// Top level of the line tracker with weighted-centroid position and PID steering.
// Each accepted scan gives exactly one result word. The front end sums probe
// weights and counts set probes in the accept cycle and queues the scan; the
// back-end sequencer then steps a tracked scan through position divide, error
// scaling, integral clamp, three gain products one per cycle and output clamp;
// a lost scan skips the gain products and output clamp. The sequencer takes a
// new scan from the queue only once it is back in idle. Scans keep being accepted
// into the queue, until it is full, while a result waits in the output register.
// Configuration writes are always ready and are registered into the config word.
`default_nettype none

module line_track_pid_steer #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [7:0]          sensor_bits_i,
  input  wire logic signed [15:0]  forward_speed_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic signed [15:0]       speed_out_o,
  output logic signed [31:0]       omega_o,
  output logic signed [14:0]       line_position_o,
  output logic signed [15:0]       line_error_o,
  output logic                     line_lost_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_data_i
);
  import ltps_pkg::*;

  pid_cfg_t   cfg_q;
  scan_item_t front_item;
  scan_item_t q_item;
  logic       q_valid;
  logic       q_pop;
  logic       push_ready;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !push_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp           <= 16'sd256;
      cfg_q.ki           <= '0;
      cfg_q.kd           <= '0;
      cfg_q.integral_max <= 24'sh7FFFFF;
      cfg_q.integral_min <= 24'sh800000;
      cfg_q.output_max   <= 32'sh7FFFFFFF;
      cfg_q.output_min   <= 32'sh80000000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_KP:      cfg_q.kp           <= cfg_data_i[15:0];
        CFG_KI:      cfg_q.ki           <= cfg_data_i[15:0];
        CFG_KD:      cfg_q.kd           <= cfg_data_i[15:0];
        CFG_INT_MAX: cfg_q.integral_max <= cfg_data_i[23:0];
        CFG_INT_MIN: cfg_q.integral_min <= cfg_data_i[23:0];
        CFG_OUT_MAX: cfg_q.output_max   <= cfg_data_i;
        CFG_OUT_MIN: cfg_q.output_min   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ltps_front u_front (
    .sensor_bits_i   (sensor_bits_i),
    .forward_speed_i (forward_speed_i),
    .item_o          (front_item)
  );

  ltps_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (push_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_item_o   (q_item)
  );

  ltps_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .speed_out_o     (speed_out_o),
    .omega_o         (omega_o),
    .line_position_o (line_position_o),
    .line_error_o    (line_error_o),
    .line_lost_o     (line_lost_o)
  );

endmodule

`default_nettype wire

>>> verif/ltps_checker.sv
// Checker for line_track_pid_steer: tracks scans and gains, predicts each steering word, compares.
`timescale 1ns / 1ps

module ltps_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire logic [7:0]         sensor_bits_i,
  input  wire logic signed [15:0] forward_speed_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire logic signed [15:0] speed_out_i,
  input  wire logic signed [31:0] omega_i,
  input  wire logic signed [14:0] line_position_i,
  input  wire logic signed [15:0] line_error_i,
  input  wire logic               line_lost_i,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  output int unsigned             backlog_o,
  output int unsigned             mismatches_o
);
  import ltps_pkg::*;

  typedef struct packed {
    logic signed [15:0] speed;
    logic signed [31:0] omega;
    logic signed [14:0] position;
    logic signed [15:0] error;
    logic               lost;
  } steer_word_t;

  logic signed [15:0] gain_p, gain_i, gain_d;
  logic signed [23:0] int_hi, int_lo;
  logic signed [31:0] out_hi, out_lo;

  logic signed [15:0] held_pos;
  logic signed [23:0] integ;
  logic signed [15:0] prev_err;
  logic signed [31:0] held_w;

  steer_word_t owed_q[$];

  function automatic longint clamp(longint v, longint hi, longint lo);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  task automatic track_scan(input logic [7:0] bits, input logic signed [15:0] speed,
                            output steer_word_t w);
    int sum_mm;
    int hits;
    longint err;
    longint acc;
    sum_mm = 0;
    hits = 0;
    for (int i = 0; i < 8; i++) begin
      if (bits[i]) begin
        sum_mm += 10 * i - 35;
        hits++;
      end
    end
    if (hits != 0) held_pos = 16'(sum_mm * 256 / hits);
    err = clamp(longint'(held_pos) * 128 / 35, 32767, -32768);
    if (hits == 0) begin
      integ = '0;
    end else begin
      integ = 24'(clamp(longint'(integ) + err, longint'(int_hi), longint'(int_lo)));
      acc = longint'(gain_p) * err + longint'(gain_i) * longint'(integ)
          + longint'(gain_d) * (err - longint'(prev_err));
      held_w = 32'(clamp(acc >>> 7, longint'(out_hi), longint'(out_lo)));
      prev_err = 16'(err);
    end
    w.speed    = speed;
    w.omega    = held_w;
    w.position = held_pos[14:0];
    w.error    = 16'(err);
    w.lost     = (hits == 0);
  endtask

  task automatic check_field(string name, longint want, longint have);
    if (want != have) begin
      $error("%s: expected %0d, got %0d", name, want, have);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    steer_word_t want;
    if (!rst_ni) begin
      gain_p       = 16'sd256;
      gain_i       = '0;
      gain_d       = '0;
      int_hi       = 24'sh7FFFFF;
      int_lo       = 24'sh800000;
      out_hi       = 32'sh7FFFFFFF;
      out_lo       = 32'sh80000000;
      held_pos     = '0;
      integ        = '0;
      prev_err     = '0;
      held_w       = '0;
      owed_q.delete();
      backlog_o    = 0;
      mismatches_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (owed_q.size() == 0) begin
          $error("steering word with none expected");
          mismatches_o++;
        end else begin
          want = owed_q.pop_front();
          check_field("speed_out", want.speed, speed_out_i);
          check_field("omega", want.omega, omega_i);
          check_field("line_position", want.position, line_position_i);
          check_field("line_error", want.error, line_error_i);
          check_field("line_lost", want.lost, line_lost_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_KP:      gain_p = cfg_data_i[15:0];
          CFG_KI:      gain_i = cfg_data_i[15:0];
          CFG_KD:      gain_d = cfg_data_i[15:0];
          CFG_INT_MAX: int_hi = cfg_data_i[23:0];
          CFG_INT_MIN: int_lo = cfg_data_i[23:0];
          CFG_OUT_MAX: out_hi = cfg_data_i;
          CFG_OUT_MIN: out_lo = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        track_scan(sensor_bits_i, forward_speed_i, want);
        owed_q.push_back(want);
      end
      backlog_o = owed_q.size();
    end
  end

endmodule

>>> verif/tb.sv
// Testbench top for line_track_pid_steer: clock, reset, scan and gain stimulus, verdict.
`timescale 1ns / 1ps

module tb;
  import ltps_pkg::*;

  localparam logic [2:0] CfgSpare = 3'd7;
  localparam int unsigned PhaseItems = 240;
  localparam int unsigned SendIdle [4] = '{0, 64, 0, 19};
  localparam int unsigned RecvStall [4] = '{0, 0, 64, 19};
  localparam logic [7:0] DirBits [20] = '{
    8'h00, 8'h01, 8'h80, 8'hFF, 8'h18, 8'h03, 8'hC0, 8'h00, 8'h00, 8'h81,
    8'h7F, 8'hFE, 8'h10, 8'h08, 8'hE0, 8'h07, 8'h00, 8'h55, 8'hAA, 8'h40
  };
  localparam logic [15:0] DirSpeed [20] = '{
    16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA, 16'h1234,
    16'h8001, 16'h7FFE, 16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0,
    16'h7FFF, 16'h8000, 16'h3C3C, 16'hC3C3
  };

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         sensor_bits_i;
  logic signed [15:0] forward_speed_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] speed_out_o;
  logic signed [31:0] omega_o;
  logic signed [14:0] line_position_o;
  logic signed [15:0] line_error_o;
  logic               line_lost_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;

  int unsigned backlog;
  int unsigned mismatches;
  int unsigned send_idle;
  int unsigned recv_stall;
  bit          hold_rx;

  line_track_pid_steer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sensor_bits_i   (sensor_bits_i),
    .forward_speed_i (forward_speed_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .speed_out_o     (speed_out_o),
    .omega_o         (omega_o),
    .line_position_o (line_position_o),
    .line_error_o    (line_error_o),
    .line_lost_o     (line_lost_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  ltps_checker steer_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .sensor_bits_i   (sensor_bits_i),
    .forward_speed_i (forward_speed_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .speed_out_i     (speed_out_o),
    .omega_i         (omega_o),
    .line_position_i (line_position_o),
    .line_error_i    (line_error_o),
    .line_lost_i     (line_lost_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .backlog_o       (backlog),
    .mismatches_o    (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("line_track_pid_steer verification failed");
    $finish;
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= hold_rx || ($urandom_range(99) < recv_stall);
    end
  end

  function automatic logic [7:0] pick_pattern();
    int unsigned roll;
    int unsigned span;
    int unsigned at;
    roll = $urandom_range(99);
    if (roll < 8) return 8'h00;
    if (roll < 20) return 8'($urandom);
    span = $urandom_range(1, 3);
    at = $urandom_range(0, 8 - span);
    return 8'(((1 << span) - 1) << at);
  endfunction

  function automatic logic [15:0] pick_speed();
    if ($urandom_range(99) < 10) begin
      case ($urandom_range(3))
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    return 16'($urandom);
  endfunction

  task automatic send_scan(input logic [7:0] bits, input logic [15:0] speed);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      sensor_bits_i <= 8'($urandom);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sensor_bits_i <= bits;
    forward_speed_i <= speed;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (backlog != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic load_gains(input logic [15:0] p, input logic [15:0] i, input logic [15:0] d,
                            input logic [23:0] ihi, input logic [23:0] ilo,
                            input logic [31:0] ohi, input logic [31:0] olo);
    wait_idle();
    cfg_write(CFG_KP, {16'($urandom), p});
    cfg_write(CFG_KI, {16'($urandom), i});
    cfg_write(CFG_KD, {16'($urandom), d});
    cfg_write(CFG_INT_MAX, {8'($urandom), ihi});
    cfg_write(CFG_INT_MIN, {8'($urandom), ilo});
    cfg_write(CFG_OUT_MAX, ohi);
    cfg_write(CFG_OUT_MIN, olo);
    // unmapped index, must not disturb any gain
    cfg_write(CfgSpare, $urandom);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    sensor_bits_i = '0;
    forward_speed_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    send_idle = 0;
    recv_stall = 0;
    hold_rx = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed scans under reset gains
    foreach (DirBits[k]) send_scan(DirBits[k], DirSpeed[k]);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: load_gains(16'sd256, 16'sd0, 16'sd0, 24'sh7FFFFF, 24'sh800000,
                      32'sh7FFFFFFF, 32'sh80000000);
        1: load_gains(16'h7FFF, 16'h8000, 16'h7FFF, 24'sh7FFFFF, 24'sh800000,
                      32'sh7FFFFFFF, 32'sh80000000);
        2: load_gains(16'h8000, 16'h7FFF, 16'h8000, 24'sd100000, -24'sd100000,
                      32'sd1048576, -32'sd1048576);
        3: load_gains(16'sd300, 16'sd40, -16'sd500, -24'sd5000, 24'sd5000,
                      -32'sd2000, 32'sd2000);
        default: load_gains(16'($urandom), 16'($urandom), 16'($urandom),
                            24'($urandom), 24'($urandom), $urandom, $urandom);
      endcase
      if (ph == 2) begin
        // long receiver hold so the input side backs up
        fork
          begin
            hold_rx = 1'b1;
            repeat (400) @(posedge clk_i);
            hold_rx = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < PhaseItems; n++) begin
        send_idle = SendIdle[(n / 60) % 4];
        recv_stall = RecvStall[(n / 60) % 4];
        send_scan(pick_pattern(), pick_speed());
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("line_track_pid_steer verification clean");
    end else begin
      $display("line_track_pid_steer verification failed");
    end
    $finish;
  end

endmodule
